// ----- hw/rtl/jsu_pkg.sv -----
// shared types, codes and helper functions for the json string unescaper
package jsu_pkg;

    // command queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // error codes on the result channel
    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_NO_QUOTE = 3'd1;
    localparam logic [2:0] ERR_ESCAPE   = 3'd2;
    localparam logic [2:0] ERR_HEX      = 3'd3;
    localparam logic [2:0] ERR_TRUNC    = 3'd4;

    // characters the scanner looks for
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    // control characters produced by single-letter escapes
    localparam logic [7:0] CTL_BS = 8'h08;
    localparam logic [7:0] CTL_FF = 8'h0C;
    localparam logic [7:0] CTL_LF = 8'h0A;
    localparam logic [7:0] CTL_CR = 8'h0D;
    localparam logic [7:0] CTL_HT = 8'h09;

    // utf-8 range limits
    localparam logic [15:0] UTF8_ONE_MAX = 16'h0080;
    localparam logic [15:0] UTF8_TWO_MAX = 16'h0800;

    // scanner state
    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_STR,
        MODE_ESC,
        MODE_HEX
    } mode_t;

    // kind of work handed from front to back
    typedef enum logic [1:0] {
        CMD_BYTE,
        CMD_CP,
        CMD_END,
        CMD_ERR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] value;
        logic [2:0]  err;
    } cmd_t;

    // queue status seen by the front
    typedef struct packed {
        logic full;
        logic push;
    } q_ctl_t;

    // hex digit decode: bit 4 set when the byte is a hex digit
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b inside {[8'h30:8'h39]}) begin
            r = {1'b1, b[3:0]};
        end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

    // number of result transactions a command expands to
    function automatic logic [1:0] cmd_len(input cmd_t c);
        logic [1:0] n;
        n = 2'd1;
        if (c.kind == CMD_CP) begin
            if (c.value < UTF8_ONE_MAX) begin
                n = 2'd1;
            end else if (c.value < UTF8_TWO_MAX) begin
                n = 2'd2;
            end else begin
                n = 2'd3;
            end
        end
        return n;
    endfunction

    // utf-8 byte number idx of a code point that encodes in n bytes
    function automatic logic [7:0] utf8_byte(input logic [15:0] cp, input logic [1:0] n,
                                             input logic [1:0] idx);
        logic [7:0] r;
        r = cp[7:0];
        if (n == 2'd2) begin
            r = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
        end else if (n == 2'd3) begin
            case (idx)
                2'd0:    r = {4'b1110, cp[15:12]};
                2'd1:    r = {2'b10, cp[11:6]};
                default: r = {2'b10, cp[5:0]};
            endcase
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/jsu_front.sv -----
// front end: accepts raw bytes, tracks string state and issues commands
module jsu_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    in_byte,
    input  logic          end_of_input,
    input  logic          q_full,
    output jsu_pkg::q_ctl_t q_ctl,
    output jsu_pkg::cmd_t q_cmd
);
    import jsu_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [1:0]  hex_cnt_reg, hex_cnt_next;
    logic [15:0] cp_reg, cp_next;
    logic        accept;
    logic        push;
    logic [4:0]  hex;
    logic [15:0] cp_shift;
    cmd_t        cmd;

    // any transaction may need a queue slot, so hold off while full
    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;
    assign hex      = hex_decode(in_byte);
    assign cp_shift = {cp_reg[11:0], hex[3:0]};

    // state register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg    <= MODE_IDLE;
            hex_cnt_reg <= 2'd0;
            cp_reg      <= 16'd0;
        end else begin
            mode_reg    <= mode_next;
            hex_cnt_reg <= hex_cnt_next;
            cp_reg      <= cp_next;
        end
    end

    // classify the byte and build the command
    always_comb begin
        mode_next    = mode_reg;
        hex_cnt_next = hex_cnt_reg;
        cp_next      = cp_reg;
        push         = 1'b0;
        cmd.kind     = CMD_BYTE;
        cmd.value    = {8'd0, in_byte};
        cmd.err      = ERR_OK;
        if (accept) begin
            if (end_of_input) begin
                push         = 1'b1;
                cmd.kind     = CMD_ERR;
                cmd.err      = (mode_reg == MODE_IDLE) ? ERR_NO_QUOTE : ERR_TRUNC;
                mode_next    = MODE_IDLE;
                hex_cnt_next = 2'd0;
                cp_next      = 16'd0;
            end else begin
                case (mode_reg)
                    MODE_IDLE: begin
                        if (in_byte == CH_QUOTE) begin
                            mode_next = MODE_STR;
                        end else begin
                            push     = 1'b1;
                            cmd.kind = CMD_ERR;
                            cmd.err  = ERR_NO_QUOTE;
                        end
                    end
                    MODE_STR: begin
                        if (in_byte == CH_QUOTE) begin
                            push      = 1'b1;
                            cmd.kind  = CMD_END;
                            mode_next = MODE_IDLE;
                        end else if (in_byte == CH_BSLASH) begin
                            mode_next = MODE_ESC;
                        end else begin
                            push = 1'b1;
                        end
                    end
                    MODE_ESC: begin
                        mode_next = MODE_STR;
                        push      = 1'b1;
                        case (in_byte)
                            CH_QUOTE, CH_BSLASH, CH_SLASH: cmd.value = {8'd0, in_byte};
                            CH_B: cmd.value = {8'd0, CTL_BS};
                            CH_F: cmd.value = {8'd0, CTL_FF};
                            CH_N: cmd.value = {8'd0, CTL_LF};
                            CH_R: cmd.value = {8'd0, CTL_CR};
                            CH_T: cmd.value = {8'd0, CTL_HT};
                            CH_U: begin
                                push         = 1'b0;
                                mode_next    = MODE_HEX;
                                hex_cnt_next = 2'd0;
                                cp_next      = 16'd0;
                            end
                            default: begin
                                cmd.kind  = CMD_ERR;
                                cmd.err   = ERR_ESCAPE;
                                mode_next = MODE_IDLE;
                            end
                        endcase
                    end
                    default: begin
                        if (!hex[4]) begin
                            push         = 1'b1;
                            cmd.kind     = CMD_ERR;
                            cmd.err      = ERR_HEX;
                            mode_next    = MODE_IDLE;
                            hex_cnt_next = 2'd0;
                            cp_next      = 16'd0;
                        end else if (hex_cnt_reg == 2'd3) begin
                            push         = 1'b1;
                            cmd.kind     = CMD_CP;
                            cmd.value    = cp_shift;
                            mode_next    = MODE_STR;
                            hex_cnt_next = 2'd0;
                            cp_next      = 16'd0;
                        end else begin
                            cp_next      = cp_shift;
                            hex_cnt_next = hex_cnt_reg + 2'd1;
                        end
                    end
                endcase
            end
        end
    end

    assign q_ctl.full = q_full;
    assign q_ctl.push = push;
    assign q_cmd      = cmd;

    // commands are only issued for accepted transactions
    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> accept)
        else $error("command pushed without an accepted byte");

    // hex counter is cleared whenever hex gathering is left
    a_hex_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != MODE_HEX) |-> (hex_cnt_reg == 2'd0))
        else $error("hex count nonzero outside hex digits");

endmodule

// ----- hw/rtl/jsu_queue.sv -----
// short command queue between front and back
module jsu_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  jsu_pkg::q_ctl_t q_ctl,
    input  jsu_pkg::cmd_t   push_cmd,
    input  logic            pop,
    output logic            full,
    output logic            head_valid,
    output jsu_pkg::cmd_t   head
);
    import jsu_pkg::*;

    cmd_t            mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0] count_reg, count_next;

    // storage write
    always_ff @(posedge clk) begin
        if (q_ctl.push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_comb begin
        wr_ptr_next = q_ctl.push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (q_ctl.push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !q_ctl.push) begin
            count_next = count_reg - 1'b1;
        end
    end

    assign full       = (count_reg == Q_CW'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    // no overflow
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_ctl.push |-> !q_ctl.full)
        else $error("push into a full queue");

    // no underflow
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from an empty queue");

endmodule

// ----- hw/rtl/jsu_back.sv -----
// back end: expands commands into result transactions through an output register
module jsu_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  jsu_pkg::cmd_t head,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    out_byte,
    output logic          byte_valid,
    output logic          string_end,
    output logic [2:0]    error_code,
    output logic          last
);
    import jsu_pkg::*;

    logic       out_valid_reg, out_valid_next;
    logic [1:0] idx_reg, idx_next;
    logic [7:0] byte_reg;
    logic       bvalid_reg;
    logic       send_reg;
    logic [2:0] err_reg;
    logic       last_reg;
    logic       load;
    logic [1:0] len;
    logic       at_last;
    logic [7:0] byte_val;

    assign len     = cmd_len(head);
    assign at_last = (idx_reg == len - 2'd1);
    assign load    = head_valid && (!out_valid_reg || !out_stall);
    assign pop     = load && at_last;

    // byte for the current position of the command
    always_comb begin
        case (head.kind)
            CMD_BYTE: byte_val = head.value[7:0];
            CMD_CP:   byte_val = utf8_byte(head.value, len, idx_reg);
            default:  byte_val = 8'd0;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end else begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (!out_stall) begin
            out_valid_next = 1'b0;
        end
        idx_next = idx_reg;
        if (pop) begin
            idx_next = 2'd0;
        end else if (load) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    // output payload
    always_ff @(posedge clk) begin
        if (load) begin
            byte_reg   <= byte_val;
            bvalid_reg <= (head.kind == CMD_BYTE) || (head.kind == CMD_CP);
            send_reg   <= (head.kind == CMD_END);
            err_reg    <= (head.kind == CMD_ERR) ? head.err : ERR_OK;
            last_reg   <= at_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = byte_reg;
    assign byte_valid = bvalid_reg;
    assign string_end = send_reg;
    assign error_code = err_reg;
    assign last       = last_reg;

    // position within a command never passes the third utf-8 byte
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != 2'd3)
        else $error("expansion index out of range");

    // a partly expanded command stays at the queue head
    a_idx_holds_head: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != 2'd0) |-> head_valid)
        else $error("expansion in progress with empty queue");

endmodule

// ----- hw/rtl/json_string_unescape_core.sv -----
// top level of the streaming json string unescaper
//
//  channel  handshake             payload
//  input    in_valid / in_stall   in_byte, end_of_input
//  output   out_valid / out_stall out_byte, byte_valid, string_end, error_code, last
//
//  one input byte accepted per cycle while the four-entry command queue has room
//  a \u escape yields up to three output bytes from one command, one per cycle while out_stall is low
//  a result is valid once its command has been written to the queue and then loaded into the output register
//  rst_n clears scanner state, queue pointers and the output valid at once
//  in_stall follows queue full only; out_stall holds the output register
module json_string_unescape_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       end_of_input,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       string_end,
    output logic [2:0] error_code,
    output logic       last
);
    import jsu_pkg::*;

    q_ctl_t q_ctl;
    cmd_t   push_cmd;
    cmd_t   head;
    logic   q_full;
    logic   head_valid;
    logic   pop;

    // byte scanner
    jsu_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .q_full       (q_full),
        .q_ctl        (q_ctl),
        .q_cmd        (push_cmd)
    );

    // command queue
    jsu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_ctl      (q_ctl),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    // result expansion
    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .string_end (string_end),
        .error_code (error_code),
        .last       (last)
    );

endmodule
